[hw/rtl/prefix_code_bit_decoder_unit_defines.svh]
// Assertion helpers for the decoder RTL.
`ifndef PREFIX_CODE_BIT_DECODER_UNIT_DEFINES_SVH
`define PREFIX_CODE_BIT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PCBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pcbd_pkg.sv]
package pcbd_pkg;

  localparam int SYM_W = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W = 6;
  localparam int IDX_W = 8;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  entry_index;
    logic [SYM_W-1:0]  entry_symbol;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic              code_bit;
  } cmd_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             symbol_valid;
    logic             overflow;
  } rsp_t;

  // Table lookup result handed to the accumulator.
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] symbol;
  } match_t;

endpackage

[hw/rtl/pcbd_table.sv]
module pcbd_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [pcbd_pkg::IDX_W-1:0]             wr_index,
  input  logic [pcbd_pkg::SYM_W-1:0]             wr_symbol,
  input  logic [pcbd_pkg::CODE_W-1:0]            wr_code,
  input  logic [pcbd_pkg::LEN_W-1:0]             wr_length,
  input  logic [MAX_CODE_LEN-1:0]                probe_bits,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]      probe_count,
  output pcbd_pkg::match_t                       match
);
  import pcbd_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(MAX_CODE_LEN + 1);
  localparam int CMP_W = (CW > LEN_W) ? CW : LEN_W;
  localparam int KEY_W = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [SYM_W-1:0]         slot_symbol [TABLE_ENTRIES];
  logic [CODE_W-1:0]        slot_code   [TABLE_ENTRIES];
  logic [LEN_W-1:0]         slot_length [TABLE_ENTRIES];

  logic                     wr_in_range;
  logic [AW-1:0]            wr_addr;
  logic [CODE_W-1:0]        len_mask;
  logic [TABLE_ENTRIES-1:0] hits;
  logic [KEY_W-1:0]         probe_key;
  logic [CMP_W-1:0]         probe_len;

  assign wr_in_range = (9'(wr_index) < 9'(TABLE_ENTRIES));
  assign wr_addr = wr_index[AW-1:0];

  // Bits above the code length are dropped at load time, so a match is a plain compare.
  assign len_mask = (wr_length >= LEN_W'(CODE_W)) ? '1
                  : ((CODE_W'(1) << wr_length[$clog2(CODE_W)-1:0]) - CODE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en && wr_in_range) begin
      slot_valid[wr_addr] <= (wr_length != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      slot_symbol[wr_addr] <= wr_symbol;
      slot_code[wr_addr]   <= wr_code & len_mask;
      slot_length[wr_addr] <= wr_length;
    end
  end

  assign probe_key = KEY_W'(probe_bits);
  assign probe_len = CMP_W'(probe_count);

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hits[i] = slot_valid[i] && (CMP_W'(slot_length[i]) == probe_len) &&
                (KEY_W'(slot_code[i]) == probe_key);
    end
  end

  // Lowest index wins.
  always_comb begin
    match = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        match.hit = 1'b1;
        match.symbol = slot_symbol[i];
      end
    end
  end

endmodule

[hw/rtl/pcbd_accum.sv]
module pcbd_accum #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              code_bit,
  input  pcbd_pkg::match_t                  match,
  output logic [MAX_CODE_LEN-1:0]           probe_bits,
  output logic [$clog2(MAX_CODE_LEN+1)-1:0] probe_count,
  output pcbd_pkg::rsp_t                    rsp_next
);
  import pcbd_pkg::*;

  localparam int CW = $clog2(MAX_CODE_LEN + 1);

  logic [MAX_CODE_LEN-1:0] pending_bits;
  logic [CW-1:0]           pending_count;
  logic                    overflow;

  // pending_bits only ever holds pending_count bits, and the count stays below
  // the maximum, so the shifted-out top bit is always zero.
  assign probe_bits = {pending_bits[MAX_CODE_LEN-2:0], code_bit};
  assign probe_count = pending_count + CW'(1);
  assign overflow = !match.hit && (probe_count == CW'(MAX_CODE_LEN));

  always_comb begin
    rsp_next.symbol = match.hit ? match.symbol : '0;
    rsp_next.symbol_valid = match.hit;
    rsp_next.overflow = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= '0;
      pending_count <= '0;
    end else if (step) begin
      if (match.hit || overflow) begin
        pending_bits <= '0;
        pending_count <= '0;
      end else begin
        pending_bits <= probe_bits;
        pending_count <= probe_count;
      end
    end
  end

endmodule

[hw/rtl/prefix_code_bit_decoder_unit.sv]
// Bit-serial prefix code decoder with a fully parallel code table.
// A decode item passes the input register, then the table match and the
// result register, and waits in the input register while a result is held.
// One item per cycle otherwise, load or decode; loads produce no result.
// Reset clears slot valid bits, the bit accumulator and both pipeline valids;
// slot contents are undefined until loaded.
`include "prefix_code_bit_decoder_unit_defines.svh"

module prefix_code_bit_decoder_unit #(
  parameter int TABLE_ENTRIES = pcbd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_LEN = pcbd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  pcbd_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pcbd_pkg::rsp_t rsp
);
  import pcbd_pkg::*;

  localparam int CW = $clog2(MAX_CODE_LEN + 1);

  logic                    s1_valid;
  cmd_t                    s1;
  logic                    out_free;
  logic                    s1_fire;
  logic                    s1_decode;
  logic                    s1_load;
  match_t                  match;
  rsp_t                    rsp_next;
  logic [MAX_CODE_LEN-1:0] probe_bits;
  logic [CW-1:0]           probe_count;

  assign out_free = !rsp_valid || !rsp_stall;
  // Loads never need the result register, so they drain even while it is held.
  assign s1_fire = s1_valid && ((s1.op == OP_LOAD) || out_free);
  assign s1_decode = s1_fire && (s1.op == OP_DECODE);
  assign s1_load = s1_fire && (s1.op == OP_LOAD);
  assign cmd_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      s1 <= cmd;
    end
  end

  pcbd_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .wr_en(s1_load),
    .wr_index(s1.entry_index),
    .wr_symbol(s1.entry_symbol),
    .wr_code(s1.entry_code),
    .wr_length(s1.entry_length),
    .probe_bits(probe_bits),
    .probe_count(probe_count),
    .match(match)
  );

  pcbd_accum #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .step(s1_decode),
    .code_bit(s1.code_bit),
    .match(match),
    .probe_bits(probe_bits),
    .probe_count(probe_count),
    .rsp_next(rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_decode) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_decode) begin
      rsp <= rsp_next;
    end
  end

  `PCBD_ASSERT_NOW(a_hit_or_ovf, clk, rst, rsp_valid, !(rsp.symbol_valid && rsp.overflow), "symbol and overflow both set")
  `PCBD_ASSERT_NOW(a_sym_zero, clk, rst, rsp_valid && !rsp.symbol_valid, rsp.symbol == '0, "symbol not zero without a match")
  `PCBD_ASSERT_NEXT(a_acc_clear, clk, rst, s1_decode && (match.hit || probe_count == CW'(MAX_CODE_LEN)), probe_count == CW'(1), "accumulator not cleared after a code ended")
  `PCBD_ASSERT_NOW(a_stall_src, clk, rst, cmd_stall, s1_valid && (s1.op == OP_DECODE) && rsp_valid && rsp_stall, "input stalled without a held decode item")

endmodule
